// ===== rtl/integer_to_radix_ascii_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the integer to radix ASCII unit
// Shared forms for concurrent checks on the rising clock edge.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITRA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/itra_pkg.sv =====
// ---------------------------------------------------------------------------
// Integer to radix ASCII package
// Widths, character codes and the controller/datapath command types.
// ---------------------------------------------------------------------------
package itra_pkg;

    localparam int VALUE_W        = 63;
    localparam int RADIX_W        = 5;
    localparam int CHAR_W         = 7;
    localparam int DIGIT_W        = 4;
    localparam int WORK_W         = 64;
    localparam int BITS_PER_STEP  = 4;
    localparam int DIV_STEPS      = WORK_W / BITS_PER_STEP;
    localparam int STEP_W         = $clog2(DIV_STEPS);
    localparam int DEF_MAX_DIGITS = 64;
    localparam int RESULT_LIMIT   = 63;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_F    = 7'h46;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

    typedef struct packed {
        logic load_item;
        logic div_step;
        logic store_digit;
        logic start_emit;
        logic emit_load;
        logic err_load;
    } itra_cmd_t;

    typedef struct packed {
        logic radix_ok;
        logic step_last;
        logic quot_zero;
        logic count_full;
        logic ptr_zero;
        logic out_free;
    } itra_status_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10)
        begin
            return CHAR_ZERO + ext;
        end
        return CHAR_A + ext - 7'd10;
    endfunction

endpackage

// ===== rtl/itra_if.sv =====
// ---------------------------------------------------------------------------
// Integer to radix ASCII channels
// Valid/ready interfaces for the input number and the output characters.
// ---------------------------------------------------------------------------
interface itra_in_if;
    import itra_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itra_out_if;
    import itra_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              bad_base;

    modport source (output valid, output char_code, output last, output bad_base,
                    input ready);
    modport sink   (input valid, input char_code, input last, input bad_base,
                    output ready);
endinterface

// ===== rtl/itra_ctrl.sv =====
// ---------------------------------------------------------------------------
// Integer to radix ASCII controller
// Sequences division passes, digit storage and character output.
// ---------------------------------------------------------------------------
module itra_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  itra_pkg::itra_status_t status,
    output itra_pkg::itra_cmd_t    cmd
);
    import itra_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_LD   = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.radix_ok)
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_ERR;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.store_digit = 1'b1;
                if (status.quot_zero || status.count_full)
                begin
                    cmd.start_emit = 1'b1;
                    state_next     = S_RD;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.ptr_zero ? S_IDLE : S_RD;
                end
            end
            S_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.err_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/itra_datapath.sv =====
// ---------------------------------------------------------------------------
// Integer to radix ASCII datapath
// Four-bit-per-cycle divider, digit memory and output register.
// ---------------------------------------------------------------------------
module itra_datapath #(
    parameter int MAX_DIGITS = itra_pkg::DEF_MAX_DIGITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [itra_pkg::VALUE_W-1:0]  value,
    input  logic [itra_pkg::RADIX_W-1:0]  radix,
    input  itra_pkg::itra_cmd_t           cmd,
    output itra_pkg::itra_status_t        status,
    itra_out_if.source                    dout
);
    import itra_pkg::*;

    localparam int LIMIT = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;
    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int CW    = $clog2(LIMIT + 1);

    logic [WORK_W-1:0]  work_reg;
    logic [WORK_W-1:0]  work_next;
    logic [DIGIT_W-1:0] rem_reg;
    logic [DIGIT_W-1:0] rem_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      ptr_reg;
    logic [DIGIT_W-1:0] rd_reg;
    logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              bad_reg;
    logic              radix_in_range;

    always_comb
    begin
        logic [DIGIT_W:0]   trial;
        logic [DIGIT_W-1:0] r;
        logic [WORK_W-1:0]  w;
        r = rem_reg;
        w = work_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            trial = {r, w[WORK_W-1]};
            w     = {w[WORK_W-2:0], 1'b0};
            if (trial >= radix_reg)
            begin
                trial = trial - radix_reg;
                w[0]  = 1'b1;
            end
            r = trial[DIGIT_W-1:0];
        end
        rem_next  = r;
        work_next = w;
    end

    always_comb
    begin
        radix_in_range = radix inside {[RADIX_MIN:RADIX_MAX]};
    end

    assign status.radix_ok   = radix_in_range;
    assign status.step_last  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.quot_zero  = (work_reg == '0);
    assign status.count_full = (count_reg == CW'(LIMIT - 1));
    assign status.ptr_zero   = (ptr_reg == '0);
    assign status.out_free   = !out_valid_reg || dout.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                step_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.div_step)
                begin
                    step_reg <= step_reg + 1'b1;
                end
                if (cmd.store_digit)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.emit_load || cmd.err_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            work_reg  <= {{(WORK_W-VALUE_W){1'b0}}, value};
            rem_reg   <= '0;
            radix_reg <= radix;
        end
        else if (cmd.div_step)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
        else if (cmd.store_digit)
        begin
            rem_reg <= '0;
        end
        if (cmd.store_digit)
        begin
            digit_mem[count_reg[AW-1:0]] <= rem_reg;
        end
        rd_reg <= digit_mem[ptr_reg];
        if (cmd.start_emit)
        begin
            ptr_reg <= count_reg[AW-1:0];
        end
        else if (cmd.emit_load)
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
        if (cmd.emit_load)
        begin
            char_reg <= digit_to_char(rd_reg);
            last_reg <= (ptr_reg == '0);
            bad_reg  <= 1'b0;
        end
        else if (cmd.err_load)
        begin
            char_reg <= CHAR_NONE;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.char_code = char_reg;
    assign dout.last      = last_reg;
    assign dout.bad_base  = bad_reg;

endmodule

// ===== rtl/integer_to_radix_ascii_unit.sv =====
// ---------------------------------------------------------------------------
// Integer to radix ASCII unit
// Converts a non-negative integer to ASCII digits in a base from 2 to 16.
// ---------------------------------------------------------------------------
//  Channel  Direction  Payload                        Transfer
//  din      in         value[62:0], radix[4:0]        one number
//  dout     out        char_code[6:0], last, bad_base one character
//
// Each digit is found in 16 passes of the shared divider, which retires four
// quotient bits a cycle, followed by a step that stores the remainder.
// Output then reads each digit from memory and loads its character into the
// output register, waiting under back-pressure; a bad base loads one marker.
// A new number is accepted only when the previous one has been fully handed
// to the output register. Reset returns the controller to idle at once.
// ---------------------------------------------------------------------------
`include "integer_to_radix_ascii_unit_defines.svh"

module integer_to_radix_ascii_unit #(
    parameter int MAX_DIGITS = itra_pkg::DEF_MAX_DIGITS
) (
    input  logic       clk,
    input  logic       rst_n,
    itra_in_if.sink    din,
    itra_out_if.source dout
);
    import itra_pkg::*;

    itra_cmd_t    cmd;
    itra_status_t status;
    logic         in_ready;

    itra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    itra_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (din.value),
        .radix  (din.radix),
        .cmd    (cmd),
        .status (status),
        .dout   (dout)
    );

    assign din.ready = in_ready;

    `ITRA_ASSERT_SAME(a_bad_base_form, clk, rst_n, dout.valid && dout.bad_base, dout.last && (dout.char_code == CHAR_NONE), "bad base result is malformed")

    `ITRA_ASSERT_SAME(a_char_range, clk, rst_n, dout.valid && !dout.bad_base, ((dout.char_code >= CHAR_ZERO) && (dout.char_code <= CHAR_NINE)) || ((dout.char_code >= CHAR_A) && (dout.char_code <= CHAR_F)), "character outside digit set")

    `ITRA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, din.valid && din.ready, !din.ready, "input accepted while a number is in progress")

endmodule
